// ----- src/degenerate_triangle_census_core_assert.svh -----
// Assertion macros for the degenerate triangle census core.
`ifndef DEGENERATE_TRIANGLE_CENSUS_CORE_ASSERT_SVH
`define DEGENERATE_TRIANGLE_CENSUS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DTC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define DTC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define DTC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- src/dtc_pkg.sv -----
package dtc_pkg;
	localparam int COUNT_BITS_DEF = 32;
	localparam int VC_W = 25;
	localparam int IDX_W = 24;
	localparam int POS_W = 20;
	localparam int TEX_W = 16;
	localparam int SUM_W = 63;
	localparam int CRS_W = 42;
	localparam int SQ_W = 86;
	localparam int ROOT_W = 43;
	localparam int DET_W = 34;
	localparam int MUL_W = 22;
	localparam int HALF_W = 21;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_SQR,
		ST_ROOT,
		ST_ACC,
		ST_OUT
	} state_t;
endpackage

// ----- src/dtc_if.sv -----
interface dtc_corner_if;
	logic                              valid;
	logic                              ready;
	logic [dtc_pkg::IDX_W-1:0]         corner_index;
	logic signed [dtc_pkg::POS_W-1:0]  pos_x;
	logic signed [dtc_pkg::POS_W-1:0]  pos_y;
	logic signed [dtc_pkg::POS_W-1:0]  pos_z;
	logic signed [dtc_pkg::TEX_W-1:0]  tex_u;
	logic signed [dtc_pkg::TEX_W-1:0]  tex_v;
	logic                              last_corner;
	modport source (output valid, corner_index, pos_x, pos_y, pos_z, tex_u, tex_v,
		last_corner, input ready);
	modport sink (input valid, corner_index, pos_x, pos_y, pos_z, tex_u, tex_v,
		last_corner, output ready);
endinterface

interface dtc_total_if #(parameter int COUNT_BITS = dtc_pkg::COUNT_BITS_DEF);
	logic                        valid;
	logic                        ready;
	logic [COUNT_BITS-1:0]       tri_total;
	logic [COUNT_BITS-1:0]       zero_area_count;
	logic [COUNT_BITS-1:0]       zero_uv_area_count;
	logic [dtc_pkg::SUM_W-1:0]   zero_uv_area_sum;
	logic                        sum_saturated;
	modport source (output valid, tri_total, zero_area_count, zero_uv_area_count,
		zero_uv_area_sum, sum_saturated, input ready);
	modport sink (input valid, tri_total, zero_area_count, zero_uv_area_count,
		zero_uv_area_sum, sum_saturated, output ready);
endinterface

interface dtc_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [dtc_pkg::VC_W-1:0]  data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- src/degenerate_triangle_census_core.sv -----
// Channel   Dir  Payload
// corner    in   corner_index, pos_x/y/z, tex_u/v, last_corner
// total     out  counts, zero-UV area sum, saturation flag
// cfg       in   vertex limit
// A corner of slot 0 or 1, or one closing a skipped triangle, leaves the input ready unless it is a last corner.
// A counted triangle then holds the input low through 9 product steps and one
// accumulate step, a zero-UV one through 9 square steps and 43 root steps more.
// One shared 22x22 multiplier forms all products; root trials use shift and add.
// A last corner adds the total transfer; arst_n clears control state and totals.
// cfg is always ready; the input is not ready while a result waits.
`include "degenerate_triangle_census_core_assert.svh"
module degenerate_triangle_census_core #(
	parameter int COUNT_BITS = dtc_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	dtc_cfg_if.sink cfg,
	dtc_corner_if.sink corner,
	dtc_total_if.source total
);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [dtc_pkg::SUM_W-1:0] SMAX = '1;

	dtc_pkg::state_t state_q, state_d;
	logic [dtc_pkg::VC_W-1:0] vc_q;
	logic [1:0] slot_q;
	logic [1:0] inr_q;
	logic signed [dtc_pkg::POS_W-1:0] px_q [2], py_q [2], pz_q [2];
	logic signed [dtc_pkg::TEX_W-1:0] tu_q [2], tv_q [2];
	logic signed [dtc_pkg::POS_W:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [dtc_pkg::TEX_W:0] u1_q, v1_q, u2_q, v2_q;
	logic [3:0] step_q;
	logic [5:0] bit_q;
	logic signed [dtc_pkg::CRS_W-1:0] p_q [8];
	logic signed [dtc_pkg::CRS_W-1:0] cx_q, cy_q, cz_q;
	logic [dtc_pkg::SQ_W-1:0] sq_q;
	logic [dtc_pkg::SQ_W-1:0] rsq_q;
	logic [dtc_pkg::ROOT_W-1:0] root_q;
	logic last_q;
	logic [COUNT_BITS-1:0] tri_q, flat_q, fuv_q;
	logic [dtc_pkg::SUM_W-1:0] sum_q;
	logic sat_q;

	logic signed [dtc_pkg::MUL_W-1:0] ma, mb;
	logic signed [2*dtc_pkg::MUL_W-1:0] mp;
	logic [dtc_pkg::ROOT_W-1:0] mg;
	logic [5:0] sq_sh;
	logic signed [dtc_pkg::DET_W-1:0] det;
	logic [dtc_pkg::ROOT_W-1:0] trial;
	logic [dtc_pkg::SQ_W-1:0] trial_sq;
	logic take, all_ok, crs_zero;
	logic [dtc_pkg::SUM_W-1:0] area;
	logic [dtc_pkg::ROOT_W-1:0] one_bit;

	assign cfg.ready = 1'b1;
	assign corner.ready = (state_q == dtc_pkg::ST_IDLE);
	assign take = corner.valid && corner.ready;
	assign all_ok = inr_q[0] && inr_q[1] && ({1'b0, corner.corner_index} < vc_q);
	assign one_bit = dtc_pkg::ROOT_W'(1) << bit_q;
	assign trial = root_q | one_bit;
	// (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b); the two terms never overlap
	assign trial_sq = rsq_q + ((dtc_pkg::SQ_W'(root_q) << (bit_q + 6'd1))
		| (dtc_pkg::SQ_W'(1) << {bit_q, 1'b0}));
	assign crs_zero = (cx_q == '0) && (cy_q == '0) && (cz_q == '0);
	assign det = dtc_pkg::DET_W'(p_q[6]) - dtc_pkg::DET_W'(p_q[7]);
	assign area = dtc_pkg::SUM_W'(root_q >> 1);

	function automatic logic [dtc_pkg::ROOT_W-1:0] mag(logic signed [dtc_pkg::CRS_W-1:0] x);
		logic signed [dtc_pkg::CRS_W:0] e;
		e = {x[dtc_pkg::CRS_W-1], x};
		return dtc_pkg::ROOT_W'(e[dtc_pkg::CRS_W] ? -e : e);
	endfunction

	// Shared signed multiplier: cross and UV products, then squares in 21-bit halves.
	always_comb begin
		ma = '0;
		mb = '0;
		mg = '0;
		sq_sh = '0;
		unique case (state_q)
			dtc_pkg::ST_PROD: begin
				unique case (step_q)
					4'd0: begin ma = dtc_pkg::MUL_W'(ay_q); mb = dtc_pkg::MUL_W'(bz_q); end
					4'd1: begin ma = dtc_pkg::MUL_W'(az_q); mb = dtc_pkg::MUL_W'(by_q); end
					4'd2: begin ma = dtc_pkg::MUL_W'(az_q); mb = dtc_pkg::MUL_W'(bx_q); end
					4'd3: begin ma = dtc_pkg::MUL_W'(ax_q); mb = dtc_pkg::MUL_W'(bz_q); end
					4'd4: begin ma = dtc_pkg::MUL_W'(ax_q); mb = dtc_pkg::MUL_W'(by_q); end
					4'd5: begin ma = dtc_pkg::MUL_W'(ay_q); mb = dtc_pkg::MUL_W'(bx_q); end
					4'd6: begin ma = dtc_pkg::MUL_W'(u1_q); mb = dtc_pkg::MUL_W'(v2_q); end
					4'd7: begin ma = dtc_pkg::MUL_W'(u2_q); mb = dtc_pkg::MUL_W'(v1_q); end
					default: ;
				endcase
			end
			dtc_pkg::ST_SQR: begin
				unique case (step_q)
					4'd0, 4'd1, 4'd2: mg = mag(cx_q);
					4'd3, 4'd4, 4'd5: mg = mag(cy_q);
					default: mg = mag(cz_q);
				endcase
				unique case (step_q)
					4'd0, 4'd3, 4'd6: begin
						ma = {1'b0, mg[dtc_pkg::HALF_W-1:0]};
						mb = ma;
					end
					4'd1, 4'd4, 4'd7: begin
						ma = {1'b0, mg[2*dtc_pkg::HALF_W-1:dtc_pkg::HALF_W]};
						mb = {1'b0, mg[dtc_pkg::HALF_W-1:0]};
						sq_sh = 6'(dtc_pkg::HALF_W + 1);
					end
					default: begin
						ma = {1'b0, mg[2*dtc_pkg::HALF_W-1:dtc_pkg::HALF_W]};
						mb = ma;
						sq_sh = 6'(2 * dtc_pkg::HALF_W);
					end
				endcase
			end
			default: ;
		endcase
		mp = ma * mb;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dtc_pkg::ST_IDLE:
				if (take && slot_q == 2'd2 && all_ok) state_d = dtc_pkg::ST_PROD;
				else if (take && corner.last_corner) state_d = dtc_pkg::ST_OUT;
			dtc_pkg::ST_PROD:
				if (step_q == 4'd8) begin
					if (crs_zero || det != '0) state_d = dtc_pkg::ST_ACC;
					else state_d = dtc_pkg::ST_SQR;
				end
			dtc_pkg::ST_SQR: if (step_q == 4'd8) state_d = dtc_pkg::ST_ROOT;
			dtc_pkg::ST_ROOT: if (bit_q == '0) state_d = dtc_pkg::ST_ACC;
			dtc_pkg::ST_ACC: state_d = last_q ? dtc_pkg::ST_OUT : dtc_pkg::ST_IDLE;
			dtc_pkg::ST_OUT: if (total.ready) state_d = dtc_pkg::ST_IDLE;
			default: state_d = dtc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		total.valid = (state_q == dtc_pkg::ST_OUT);
		total.tri_total = tri_q;
		total.zero_area_count = flat_q;
		total.zero_uv_area_count = fuv_q;
		total.zero_uv_area_sum = sum_q;
		total.sum_saturated = sat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtc_pkg::ST_IDLE;
			vc_q <= '0;
			slot_q <= '0;
			inr_q <= '0;
			step_q <= '0;
			bit_q <= '0;
			last_q <= 1'b0;
			tri_q <= '0;
			flat_q <= '0;
			fuv_q <= '0;
			sum_q <= '0;
			sat_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) vc_q <= cfg.data;
			unique case (state_q)
				dtc_pkg::ST_IDLE: begin
					step_q <= '0;
					if (take) begin
						last_q <= corner.last_corner;
						if (slot_q == 2'd2 || corner.last_corner) begin
							slot_q <= '0;
							inr_q <= '0;
						end else begin
							slot_q <= slot_q + 2'd1;
							inr_q[slot_q[0]] <= ({1'b0, corner.corner_index} < vc_q);
						end
						if (slot_q == 2'd2 && all_ok) tri_q <= (tri_q == CMAX) ? tri_q : tri_q + 1'b1;
					end
				end
				dtc_pkg::ST_PROD: begin
					step_q <= (step_q == 4'd8) ? 4'd0 : step_q + 4'd1;
					if (step_q == 4'd8 && crs_zero) flat_q <= (flat_q == CMAX) ? flat_q : flat_q + 1'b1;
				end
				dtc_pkg::ST_SQR: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd8) bit_q <= 6'(dtc_pkg::ROOT_W - 1);
				end
				dtc_pkg::ST_ROOT: begin
					bit_q <= bit_q - 6'd1;
				end
				dtc_pkg::ST_ACC: begin
					if (!crs_zero && det == '0) begin
						fuv_q <= (fuv_q == CMAX) ? fuv_q : fuv_q + 1'b1;
						if (area >= SMAX - sum_q) begin
							sum_q <= SMAX;
							sat_q <= 1'b1;
						end else begin
							sum_q <= sum_q + area;
						end
					end
				end
				dtc_pkg::ST_OUT: begin
					if (total.ready) begin
						tri_q <= '0;
						flat_q <= '0;
						fuv_q <= '0;
						sum_q <= '0;
						sat_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers, no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			if (slot_q != 2'd2) begin
				px_q[slot_q[0]] <= corner.pos_x;
				py_q[slot_q[0]] <= corner.pos_y;
				pz_q[slot_q[0]] <= corner.pos_z;
				tu_q[slot_q[0]] <= corner.tex_u;
				tv_q[slot_q[0]] <= corner.tex_v;
			end else begin
				ax_q <= (dtc_pkg::POS_W+1)'(px_q[1]) - (dtc_pkg::POS_W+1)'(px_q[0]);
				ay_q <= (dtc_pkg::POS_W+1)'(py_q[1]) - (dtc_pkg::POS_W+1)'(py_q[0]);
				az_q <= (dtc_pkg::POS_W+1)'(pz_q[1]) - (dtc_pkg::POS_W+1)'(pz_q[0]);
				bx_q <= (dtc_pkg::POS_W+1)'(corner.pos_x) - (dtc_pkg::POS_W+1)'(px_q[0]);
				by_q <= (dtc_pkg::POS_W+1)'(corner.pos_y) - (dtc_pkg::POS_W+1)'(py_q[0]);
				bz_q <= (dtc_pkg::POS_W+1)'(corner.pos_z) - (dtc_pkg::POS_W+1)'(pz_q[0]);
				u1_q <= (dtc_pkg::TEX_W+1)'(tu_q[1]) - (dtc_pkg::TEX_W+1)'(tu_q[0]);
				v1_q <= (dtc_pkg::TEX_W+1)'(tv_q[1]) - (dtc_pkg::TEX_W+1)'(tv_q[0]);
				u2_q <= (dtc_pkg::TEX_W+1)'(corner.tex_u) - (dtc_pkg::TEX_W+1)'(tu_q[0]);
				v2_q <= (dtc_pkg::TEX_W+1)'(corner.tex_v) - (dtc_pkg::TEX_W+1)'(tv_q[0]);
			end
		end
		unique case (state_q)
			dtc_pkg::ST_PROD: begin
				if (step_q < 4'd8) p_q[step_q[2:0]] <= dtc_pkg::CRS_W'(mp);
				if (step_q == 4'd7) begin
					cx_q <= p_q[0] - p_q[1];
					cy_q <= p_q[2] - p_q[3];
					cz_q <= p_q[4] - p_q[5];
				end
				sq_q <= '0;
				rsq_q <= '0;
				root_q <= '0;
			end
			dtc_pkg::ST_SQR: sq_q <= sq_q + (dtc_pkg::SQ_W'($unsigned(mp)) << sq_sh);
			dtc_pkg::ST_ROOT: begin
				if (trial_sq <= sq_q) begin
					root_q <= trial;
					rsq_q <= trial_sq;
				end
			end
			default: ;
		endcase
	end

	`DTC_ASSERT_NEXT(a_busy, clk, arst_n, take && slot_q == 2'd2 && all_ok, !corner.ready, "triangle not started")
	`DTC_ASSERT_IMPL(a_sat, clk, arst_n, sat_q |-> sum_q == SMAX, "flag without full sum")
	`DTC_ASSERT_IMPL(a_slot, clk, arst_n, slot_q != 2'd3, "bad corner slot")
	`DTC_ASSERT_NEXT(a_out, clk, arst_n, total.valid && !total.ready, total.valid && $stable(tri_q), "result dropped")
endmodule

// ----- dv/tb_degenerate_triangle_census_core.sv -----
`timescale 1ns / 100ps

module tb_degenerate_triangle_census_core;
	typedef struct {
		logic [31:0] tri_cnt;
		logic [31:0] flat_cnt;
		logic [31:0] uv_cnt;
		logic [62:0] area;
		logic        sat;
	} totals_t;

	class census_board;
		localparam logic [62:0] AREA_MAX = {63{1'b1}};

		logic [24:0] vcount;
		int unsigned slot;
		longint hp[2][3];
		longint ht[2][2];
		bit hok[2];
		logic [31:0] n_tri, n_flat, n_uv;
		logic [62:0] area_acc;
		bit clipped;
		totals_t pending[$];
		int errors;

		function new();
			vcount = 0;
			errors = 0;
			clear();
		endfunction

		function void clear();
			slot = 0;
			hok[0] = 0;
			hok[1] = 0;
			n_tri = 0;
			n_flat = 0;
			n_uv = 0;
			area_acc = 0;
			clipped = 0;
		endfunction

		function logic [31:0] sat_inc(logic [31:0] c);
			return (c == 32'hFFFF_FFFF) ? c : c + 1;
		endfunction

		function logic [42:0] root86(logic [85:0] s);
			logic [42:0] r;
			logic [42:0] t;
			r = 0;
			for (int b = 42; b >= 0; b--) begin
				t = r | (43'd1 << b);
				if ({43'd0, t} * {43'd0, t} <= s)
					r = t;
			end
			return r;
		endfunction

		function void judge(longint p[3][3], longint t[3][2]);
			longint ax, ay, az, bx, by, bz, cx, cy, cz, du1, dv1, du2, dv2, det;
			logic [85:0] sq;
			logic [85:0] mx, my, mz;
			logic [62:0] a;
			ax = p[1][0] - p[0][0]; ay = p[1][1] - p[0][1]; az = p[1][2] - p[0][2];
			bx = p[2][0] - p[0][0]; by = p[2][1] - p[0][1]; bz = p[2][2] - p[0][2];
			cx = ay * bz - az * by;
			cy = az * bx - ax * bz;
			cz = ax * by - ay * bx;
			du1 = t[1][0] - t[0][0]; dv1 = t[1][1] - t[0][1];
			du2 = t[2][0] - t[0][0]; dv2 = t[2][1] - t[0][1];
			det = du1 * dv2 - du2 * dv1;
			n_tri = sat_inc(n_tri);
			if (cx == 0 && cy == 0 && cz == 0) begin
				n_flat = sat_inc(n_flat);
			end else if (det == 0) begin
				mx = (cx < 0) ? -cx : cx;
				my = (cy < 0) ? -cy : cy;
				mz = (cz < 0) ? -cz : cz;
				sq = mx * mx + my * my + mz * mz;
				a = {20'd0, root86(sq)} >> 1;
				n_uv = sat_inc(n_uv);
				if (a >= AREA_MAX - area_acc)
					area_acc = AREA_MAX;
				else
					area_acc = area_acc + a;
				if (area_acc == AREA_MAX)
					clipped = 1;
			end
		endfunction

		function void note_corner(logic [23:0] idx, logic signed [19:0] x, y, z,
			logic signed [15:0] u, v, logic last);
			bit ok;
			longint p[3][3];
			longint t[3][2];
			totals_t e;
			ok = ({1'b0, idx} < vcount);
			if (slot < 2) begin
				hp[slot][0] = x; hp[slot][1] = y; hp[slot][2] = z;
				ht[slot][0] = u; ht[slot][1] = v;
				hok[slot] = ok;
				slot++;
			end else begin
				if (hok[0] && hok[1] && ok) begin
					for (int i = 0; i < 2; i++) begin
						for (int j = 0; j < 3; j++)
							p[i][j] = hp[i][j];
						t[i][0] = ht[i][0];
						t[i][1] = ht[i][1];
					end
					p[2][0] = x; p[2][1] = y; p[2][2] = z;
					t[2][0] = u; t[2][1] = v;
					judge(p, t);
				end
				slot = 0;
			end
			if (last) begin
				e.tri_cnt = n_tri;
				e.flat_cnt = n_flat;
				e.uv_cnt = n_uv;
				e.area = area_acc;
				e.sat = clipped;
				pending = {pending, e};
				clear();
			end
		endfunction

		function void check_totals(totals_t got);
			totals_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected totals transfer", $time);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.tri_cnt !== e.tri_cnt) begin
				$display("%0t: tri_total exp %0d got %0d", $time, e.tri_cnt, got.tri_cnt);
				errors++;
			end
			if (got.flat_cnt !== e.flat_cnt) begin
				$display("%0t: zero_area_count exp %0d got %0d", $time, e.flat_cnt, got.flat_cnt);
				errors++;
			end
			if (got.uv_cnt !== e.uv_cnt) begin
				$display("%0t: zero_uv_area_count exp %0d got %0d", $time, e.uv_cnt, got.uv_cnt);
				errors++;
			end
			if (got.area !== e.area) begin
				$display("%0t: zero_uv_area_sum exp %0h got %0h", $time, e.area, got.area);
				errors++;
			end
			if (got.sat !== e.sat) begin
				$display("%0t: sum_saturated exp %0b got %0b", $time, e.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;

	dtc_cfg_if cfg();
	dtc_corner_if corner();
	dtc_total_if total();

	degenerate_triangle_census_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.corner(corner.sink),
		.total(total.source)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	census_board board = new();
	int idle_cycles = 0;
	bit timed_out = 0;
	bit rx_enable = 0;

	initial begin
		cfg.valid = 0;
		cfg.data = 0;
		corner.valid = 0;
		corner.corner_index = 0;
		corner.pos_x = 0;
		corner.pos_y = 0;
		corner.pos_z = 0;
		corner.tex_u = 0;
		corner.tex_v = 0;
		corner.last_corner = 0;
		total.ready = 0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		if ((corner.valid && corner.ready) || (total.valid && total.ready)
			|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		totals_t got;
		if (total.valid && total.ready) begin
			got.tri_cnt = total.tri_total;
			got.flat_cnt = total.zero_area_count;
			got.uv_cnt = total.zero_uv_area_count;
			got.area = total.zero_uv_area_sum;
			got.sat = total.sum_saturated;
			board.check_totals(got);
		end
	end

	initial begin
		int g;
		@(posedge clk iff rx_enable);
		forever begin
			g = gap_len();
			if (g > 0) begin
				total.ready <= 0;
				repeat (g) @(posedge clk);
			end
			total.ready <= 1;
			@(posedge clk);
		end
	end

	task automatic write_vcount(logic [24:0] v);
		cfg.valid <= 1;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		board.vcount = v;
		cfg.valid <= 0;
	endtask

	task automatic send_corner(logic [23:0] idx, logic signed [19:0] x, y, z,
		logic signed [15:0] u, v, logic last);
		int g;
		g = gap_len();
		if (g > 0) begin
			corner.valid <= 0;
			repeat (g) @(posedge clk);
		end
		corner.valid <= 1;
		corner.corner_index <= idx;
		corner.pos_x <= x;
		corner.pos_y <= y;
		corner.pos_z <= z;
		corner.tex_u <= u;
		corner.tex_v <= v;
		corner.last_corner <= last;
		@(posedge clk);
		while (!corner.ready)
			@(posedge clk);
		board.note_corner(idx, x, y, z, u, v, last);
	endtask

	task automatic drain();
		corner.valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic rand_corner(logic [24:0] vc, bit last);
		logic [23:0] idx;
		logic signed [19:0] x, y, z;
		logic signed [15:0] u, v;
		int m;
		m = $urandom_range(0, 9);
		if (m < 8 && vc != 0)
			idx = (vc > 25'h100_0000) ? 24'($urandom) : 24'($urandom_range(0, vc - 1));
		else
			idx = 24'($urandom);
		x = 20'($urandom); y = 20'($urandom); z = 20'($urandom);
		u = 16'($urandom); v = 16'($urandom);
		if (m < 3) begin
			x = 20'($urandom_range(0, 7)); y = 20'($urandom_range(0, 7)); z = 0;
			u = 0; v = 16'($urandom_range(0, 3));
		end
		send_corner(idx, x, y, z, u, v, last);
	endtask

	task automatic send_tri(logic [24:0] vc, bit close);
		int kind;
		logic signed [19:0] x0, y0, z0, dx, dy, dz;
		logic signed [15:0] u0;
		kind = $urandom_range(0, 3);
		if (kind == 0) begin
			rand_corner(vc, 0);
			rand_corner(vc, 0);
			rand_corner(vc, close);
		end else begin
			x0 = 20'($urandom); y0 = 20'($urandom); z0 = 20'($urandom);
			dx = 20'($urandom_range(0, 3000)); dy = 20'($urandom_range(0, 3000));
			dz = 20'($urandom_range(0, 3000));
			u0 = 16'($urandom);
			send_corner(0, x0, y0, z0, u0, 16'($urandom), 0);
			send_corner(1, x0 + dx, y0 + dy, z0, u0, 16'($urandom), 0);
			if (kind == 1)
				send_corner(2, 20'(x0 + 2 * dx), 20'(y0 + 2 * dy), z0, u0,
					16'($urandom), close);
			else
				send_corner(2, x0 - dy, y0 + dz, z0 + dx, u0, 16'($urandom), close);
		end
	endtask

	localparam logic signed [19:0] PMAX = 20'sh7FFFF;
	localparam logic signed [19:0] PMIN = -20'sh80000;
	localparam logic signed [15:0] TMAX = 16'sh7FFF;
	localparam logic signed [15:0] TMIN = -16'sh8000;

	initial begin
		int items;
		logic [24:0] vc;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		rx_enable = 1;

		write_vcount(25'd0);
		send_corner(0, 1, 2, 3, 4, 5, 0);
		send_corner(0, 1, 2, 3, 4, 5, 0);
		send_corner(0, 7, 2, 3, 4, 5, 1);
		drain();

		write_vcount(25'h100_0000);
		send_corner(24'hFF_FFFF, PMAX, PMAX, PMIN, TMIN, TMIN, 0);
		send_corner(0, PMIN, PMIN, PMAX, TMAX, TMIN, 0);
		send_corner(5, PMIN, PMAX, PMAX, TMAX, TMAX, 0);
		send_corner(1, PMAX, PMIN, PMAX, 0, 0, 0);
		send_corner(2, PMIN, PMAX, PMIN, 0, 0, 0);
		send_corner(3, PMIN, PMAX, PMAX, 0, 0, 0);
		send_corner(1, 5, 5, 5, 1, 1, 0);
		send_corner(1, 5, 5, 5, 2, 3, 0);
		send_corner(1, 5, 5, 5, 9, 1, 0);
		send_corner(1, 1, 2, 3, 7, 7, 0);
		send_corner(2, 4, 5, 6, 7, 7, 1);
		drain();

		write_vcount(25'h1FF_FFFF);
		send_corner(24'hFF_FFFF, 0, 0, 0, 0, 0, 0);
		send_corner(24'hFF_FFFF, 10, 0, 0, 0, 0, 0);
		send_corner(24'hFF_FFFF, 0, 10, 0, 0, 0, 1);
		drain();

		write_vcount(25'd3);
		send_corner(2, 1, 0, 0, 0, 0, 0);
		send_corner(3, 0, 1, 0, 0, 0, 0);
		send_corner(0, 0, 0, 1, 0, 0, 1);
		drain();

		items = 0;
		while (items < 850) begin
			case ($urandom_range(0, 3))
				0: vc = 25'($urandom_range(1, 8));
				1: vc = 25'(25'h100_0000 + $urandom_range(0, 1));
				2: vc = 25'($urandom);
				default: vc = $urandom_range(0, 1) ? 25'd0 : 25'h1FF_FFFF;
			endcase
			write_vcount(vc);
			for (int k = $urandom_range(0, 8); k > 0; k--) begin
				send_tri(vc, 0);
				items += 3;
			end
			if ($urandom_range(0, 3) == 0) begin
				for (int k = $urandom_range(0, 1); k > 0; k--) begin
					rand_corner(vc, 0);
					items++;
				end
				rand_corner(vc, 1);
				items++;
			end else begin
				send_tri(vc, 1);
				items += 3;
			end
			drain();
		end

		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
